// ===== rtl/eots_pkg.sv =====
// Shared types, constants and mode codes for the expiry-ordered timer set.
package eots_pkg;
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W = 4;
  localparam int MODE_W = 3;
  localparam int OUT_W = 32;

  localparam logic [MODE_W-1:0] MODE_START_AFTER = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START_AT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET_DUR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRIGGER = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0] timer_id;
    logic [31:0] time_now;
    logic [31:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic fired;
    logic [ID_W-1:0] timer_out;
    logic [31:0] expiry_time;
    logic armed_now;
    logic [31:0] next_time;
    logic last;
  } out_item_t;
endpackage

// ===== rtl/eots_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
interface eots_in_if;
  logic valid;
  logic ready;
  eots_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eots_out_if;
  logic valid;
  logic ready;
  eots_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/expiry_ordered_timer_set_core.sv =====
// Top level of the expiry-ordered timer set: control sequencer and cell chain.
// Usage: items enter on the in_ channel (valid/ready), results leave on the
// out_ channel (valid/ready) with last marking the final result of an item.
// Start, stop, set-duration and query make their update and then present one
// result. A trigger before the next-check time presents its one result
// without a scan. Otherwise it runs one scan of the cell chain per fired
// timer plus a final scan that sets the next-check time: each scan lets the
// earliest candidate ripple through the chain, and an evaluate step then
// fires it or ends the trigger. The fired timers are buffered and then
// leave one per cycle while the receiver takes them. At most 16 timers
// fire per trigger.
// One item is in work at a time; a new item is taken once the previous
// item's final result has been handed to the output register.
// The output register holds a result while out_ready is low; the sequencer
// waits, so no result is lost while the receiver stalls.
// Synchronous reset clears all timers, durations and armed flags and sets
// the next-check time to infinity (all ones).
module expiry_ordered_timer_set_core #(
  parameter int NUM_TIMERS = eots_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS = eots_pkg::TIME_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  eots_in_if.sink in_ch,
  eots_out_if.source out_ch
);
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 2);
  localparam int NF_W = $clog2(eots_pkg::MAX_RESULTS + 1);
  localparam int FI_W = $clog2(eots_pkg::MAX_RESULTS);
  localparam logic [TIME_BITS-1:0] TINF = '1;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0] state_r, state_nxt;
  eots_pkg::in_item_t item_r;
  logic [TIME_BITS-1:0] next_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NF_W-1:0] nf_r;
  logic [NF_W-1:0] rd_r;
  logic drain_last;
  logic ovld_r;
  eots_pkg::out_item_t odata_r;
  logic [eots_pkg::ID_W-1:0] fid_mem [eots_pkg::MAX_RESULTS];
  logic [TIME_BITS-1:0] fexp_mem [eots_pkg::MAX_RESULTS];

  logic [NUM_TIMERS-1:0] wr_exp, wr_dur, set_arm, clr_arm, armed;
  logic [TIME_BITS-1:0] wdata;
  logic [TIME_BITS-1:0] exps [NUM_TIMERS];
  logic [TIME_BITS-1:0] durs [NUM_TIMERS];
  logic [NUM_TIMERS:0] cv;
  logic [TIME_BITS-1:0] ce [NUM_TIMERS+1];
  logic [IDX_W-1:0] ci [NUM_TIMERS+1];
  logic scan;

  logic [TIME_BITS-1:0] now, val, dsel, sat, limit;
  logic id_ok;
  logic [IDX_W-1:0] id;
  logic out_free;

  assign now = TIME_BITS'(item_r.time_now);
  assign val = TIME_BITS'(item_r.time_value);
  assign id_ok = 32'(item_r.timer_id) < 32'(NUM_TIMERS);
  assign id = IDX_W'(item_r.timer_id);
  assign dsel = durs[id];
  assign limit = TINF - 1'b1;
  assign sat = (dsel >= limit || now > limit - dsel) ? limit : now + dsel;
  assign out_free = !ovld_r || out_ch.ready;
  assign scan = (state_r == S_SCAN);
  assign wdata = (item_r.mode == eots_pkg::MODE_START_AFTER) ? sat : val;
  assign drain_last = (rd_r + 1'b1) == nf_r;

  assign cv[0] = 1'b0;
  assign ce[0] = '0;
  assign ci[0] = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    eots_cell #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W), .IDX(g)) u_cell (
      .clk, .rst_n,
      .wr_exp(wr_exp[g]), .wr_dur(wr_dur[g]), .set_arm(set_arm[g]),
      .clr_arm(clr_arm[g]), .wdata, .scan,
      .c_in_vld(cv[g]), .c_in_exp(ce[g]), .c_in_idx(ci[g]),
      .c_out_vld(cv[g+1]), .c_out_exp(ce[g+1]), .c_out_idx(ci[g+1]),
      .exp_o(exps[g]), .dur_o(durs[g]), .armed_o(armed[g])
    );
  end

  logic exec_go, fire_go;
  assign exec_go = (state_r == S_EXEC) && out_free;
  assign fire_go = (state_r == S_EVAL) && out_free && cv[NUM_TIMERS]
                   && ce[NUM_TIMERS] <= now && nf_r < NF_W'(eots_pkg::MAX_RESULTS);

  always_comb begin
    wr_exp = '0;
    wr_dur = '0;
    set_arm = '0;
    clr_arm = '0;
    if (exec_go && id_ok) begin
      case (item_r.mode)
        eots_pkg::MODE_START_AFTER, eots_pkg::MODE_START_AT: begin
          wr_exp[id] = 1'b1;
          set_arm[id] = 1'b1;
        end
        eots_pkg::MODE_STOP: clr_arm[id] = 1'b1;
        eots_pkg::MODE_SET_DUR: wr_dur[id] = 1'b1;
        default: ;
      endcase
    end
    if (fire_go) clr_arm[ci[NUM_TIMERS]] = 1'b1;
  end

  logic is_start, arm_after, armed_after;
  assign is_start = item_r.mode == eots_pkg::MODE_START_AFTER
                    || item_r.mode == eots_pkg::MODE_START_AT;
  assign armed_after = id_ok && (is_start ||
                       (armed[id] && item_r.mode != eots_pkg::MODE_STOP));
  assign arm_after = id_ok && is_start;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (item_r.mode == eots_pkg::MODE_TRIGGER) begin
          state_nxt = (now >= next_r) ? S_SCAN : S_EMIT;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: if (cnt_r == CNT_W'(NUM_TIMERS)) state_nxt = S_EVAL;
      S_EVAL: begin
        if (out_free) state_nxt = fire_go ? S_SCAN : (nf_r == '0 ? S_EMIT : S_DRAIN);
      end
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      S_DRAIN: if (out_free && drain_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (fire_go) begin
      fid_mem[nf_r[FI_W-1:0]] <= eots_pkg::ID_W'(ci[NUM_TIMERS]);
      fexp_mem[nf_r[FI_W-1:0]] <= ce[NUM_TIMERS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      next_r <= TINF;
      cnt_r <= '0;
      nf_r <= '0;
      rd_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovld_r && out_ch.ready) ovld_r <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        item_r <= in_ch.data;
        nf_r <= '0;
        rd_r <= '0;
      end
      if (state_r == S_SCAN) cnt_r <= cnt_r + 1'b1;
      else cnt_r <= '0;
      if (exec_go && item_r.mode != eots_pkg::MODE_TRIGGER) begin
        ovld_r <= 1'b1;
        odata_r.fired <= 1'b0;
        odata_r.timer_out <= item_r.timer_id;
        odata_r.expiry_time <= armed_after ? (arm_after ? 32'(wdata) : 32'(exps[id]))
                                           : '1;
        odata_r.armed_now <= armed_after;
        odata_r.next_time <= 32'((arm_after && wdata < next_r) ? wdata : next_r);
        odata_r.last <= 1'b1;
        if (arm_after && wdata < next_r) next_r <= wdata;
      end
      if (state_r == S_EVAL && out_free) begin
        if (fire_go) begin
          nf_r <= nf_r + 1'b1;
        end else begin
          next_r <= cv[NUM_TIMERS] ? ce[NUM_TIMERS] : TINF;
        end
      end
      if (state_r == S_DRAIN && out_free) begin
        ovld_r <= 1'b1;
        odata_r.fired <= 1'b1;
        odata_r.timer_out <= fid_mem[rd_r[FI_W-1:0]];
        odata_r.expiry_time <= 32'(fexp_mem[rd_r[FI_W-1:0]]);
        odata_r.armed_now <= 1'b0;
        odata_r.next_time <= 32'(next_r);
        odata_r.last <= drain_last;
        rd_r <= rd_r + 1'b1;
      end
      if (state_r == S_EMIT && out_free) begin
        ovld_r <= 1'b1;
        odata_r.fired <= 1'b0;
        odata_r.timer_out <= '0;
        odata_r.expiry_time <= '1;
        odata_r.armed_now <= 1'b0;
        odata_r.next_time <= 32'(next_r);
        odata_r.last <= 1'b1;
      end
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.data = odata_r;
endmodule

// ===== rtl/eots_cell.sv =====
// One timer cell: holds a timer and forwards the running earliest candidate.
module eots_cell #(
  parameter int TIME_BITS = eots_pkg::TIME_BITS_DEF,
  parameter int IDX_W = 4,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_exp,
  input  logic                 wr_dur,
  input  logic                 set_arm,
  input  logic                 clr_arm,
  input  logic [TIME_BITS-1:0] wdata,
  input  logic                 scan,
  input  logic                 c_in_vld,
  input  logic [TIME_BITS-1:0] c_in_exp,
  input  logic [IDX_W-1:0]     c_in_idx,
  output logic                 c_out_vld,
  output logic [TIME_BITS-1:0] c_out_exp,
  output logic [IDX_W-1:0]     c_out_idx,
  output logic [TIME_BITS-1:0] exp_o,
  output logic [TIME_BITS-1:0] dur_o,
  output logic                 armed_o
);
  logic [TIME_BITS-1:0] exp_r, dur_r;
  logic armed_r, vld_r;
  logic [TIME_BITS-1:0] cexp_r;
  logic [IDX_W-1:0] cidx_r;
  logic take;

  assign take = armed_r && (!c_in_vld || exp_r < c_in_exp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      dur_r <= '0;
      armed_r <= 1'b0;
      vld_r <= 1'b0;
      cexp_r <= '0;
      cidx_r <= '0;
    end else begin
      if (wr_exp) exp_r <= wdata;
      if (wr_dur) dur_r <= wdata;
      if (set_arm) armed_r <= 1'b1;
      else if (clr_arm) armed_r <= 1'b0;
      if (scan) begin
        vld_r <= take || c_in_vld;
        cexp_r <= take ? exp_r : c_in_exp;
        cidx_r <= take ? IDX_W'(IDX) : c_in_idx;
      end
    end
  end

  assign c_out_vld = vld_r;
  assign c_out_exp = cexp_r;
  assign c_out_idx = cidx_r;
  assign exp_o = exp_r;
  assign dur_o = dur_r;
  assign armed_o = armed_r;
endmodule

// ===== rtl/eots_checker.sv =====
// Port-level checker for the expiry-ordered timer set, bound to the top level.
module eots_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input eots_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_fired_unarmed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |-> !out_data.armed_now)
    else $error("fired report shows armed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken mid-trigger");
  a_quiet_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.last)
    else $error("non-fired result not last");
endmodule

bind expiry_ordered_timer_set_core eots_checker u_eots_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== test/eots_checker.sv =====
// Checker for the expiry-ordered timer set: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module eots_scoreboard (
  input logic clk,
  input logic rst_n,
  eots_in_if.sink in_mon,
  eots_out_if.sink out_mon,
  output int fail_count,
  output int pending_count
);
  logic [31:0] expiry_q [16];
  logic [31:0] duration_q [16];
  logic armed_q [16];
  logic [31:0] next_check_q;
  eots_pkg::out_item_t awaited_q [$];

  assign pending_count = awaited_q.size();

  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < 16; i++)
      if (armed_q[i] && (best < 0 || expiry_q[i] < expiry_q[best])) best = i;
    return best;
  endfunction

  task automatic arm_timer(input int id, input logic [31:0] t);
    expiry_q[id] = t;
    armed_q[id] = 1'b1;
    if (t < next_check_q) next_check_q = t;
  endtask

  task automatic predict_item(input eots_pkg::in_item_t it);
    eots_pkg::out_item_t r;
    int fired_ids [$];
    int e;
    int id;
    logic [31:0] lim;
    logic [31:0] d;
    id = int'(it.timer_id);
    if (it.mode == eots_pkg::MODE_TRIGGER) begin
      if (it.time_now >= next_check_q) begin
        while (fired_ids.size() < eots_pkg::MAX_RESULTS) begin
          e = earliest_armed();
          if (e < 0 || expiry_q[e] > it.time_now) break;
          armed_q[e] = 1'b0;
          fired_ids.push_back(e);
        end
        e = earliest_armed();
        next_check_q = (e < 0) ? 32'hFFFF_FFFF : expiry_q[e];
      end
      if (fired_ids.size() == 0) begin
        r = '{fired: 1'b0, timer_out: '0, expiry_time: 32'hFFFF_FFFF, armed_now: 1'b0,
              next_time: next_check_q, last: 1'b1};
        awaited_q.push_back(r);
      end else begin
        foreach (fired_ids[k]) begin
          r = '{fired: 1'b1, timer_out: fired_ids[k][3:0], expiry_time: expiry_q[fired_ids[k]],
                armed_now: 1'b0, next_time: next_check_q,
                last: (k == fired_ids.size() - 1)};
          awaited_q.push_back(r);
        end
      end
    end else begin
      lim = 32'hFFFF_FFFE;
      case (it.mode)
        eots_pkg::MODE_START_AFTER: begin
          d = duration_q[id];
          if (d >= lim || it.time_now > lim - d) arm_timer(id, lim);
          else arm_timer(id, it.time_now + d);
        end
        eots_pkg::MODE_START_AT: arm_timer(id, it.time_value);
        eots_pkg::MODE_STOP: armed_q[id] = 1'b0;
        eots_pkg::MODE_SET_DUR: duration_q[id] = it.time_value;
        default: ;
      endcase
      r = '{fired: 1'b0, timer_out: it.timer_id,
            expiry_time: armed_q[id] ? expiry_q[id] : 32'hFFFF_FFFF,
            armed_now: armed_q[id], next_time: next_check_q, last: 1'b1};
      awaited_q.push_back(r);
    end
  endtask

  task automatic compare_result(input eots_pkg::out_item_t got);
    eots_pkg::out_item_t want;
    if (awaited_q.size() == 0) begin
      $error("unexpected result transaction %p", got);
      fail_count++;
      return;
    end
    want = awaited_q.pop_front();
    if (got.fired !== want.fired) begin
      $error("fired: expected %0h actual %0h", want.fired, got.fired); fail_count++;
    end
    if (got.timer_out !== want.timer_out) begin
      $error("timer_out: expected %0h actual %0h", want.timer_out, got.timer_out); fail_count++;
    end
    if (got.expiry_time !== want.expiry_time) begin
      $error("expiry_time: expected %0h actual %0h", want.expiry_time, got.expiry_time);
      fail_count++;
    end
    if (got.armed_now !== want.armed_now) begin
      $error("armed_now: expected %0h actual %0h", want.armed_now, got.armed_now); fail_count++;
    end
    if (got.next_time !== want.next_time) begin
      $error("next_time: expected %0h actual %0h", want.next_time, got.next_time); fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0h actual %0h", want.last, got.last); fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        expiry_q[i] = '0;
        duration_q[i] = '0;
        armed_q[i] = 1'b0;
      end
      next_check_q = 32'hFFFF_FFFF;
      awaited_q.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) compare_result(out_mon.data);
      if (in_mon.valid && in_mon.ready) predict_item(in_mon.data);
    end
  end

  final begin
    if (awaited_q.size() != 0) $error("%0d results never arrived", awaited_q.size());
  end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the expiry-ordered timer set: stimulus, idling, verdict.
`timescale 1ns / 1ps
module tb_top;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int fail_count;
  int pending_count;
  int cycle_count = 0;
  bit hold_off = 1'b0;

  eots_in_if in_ch ();
  eots_out_if out_ch ();

  expiry_ordered_timer_set_core DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  eots_scoreboard u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: stall pattern, with a long hold-off on request
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else if ((stall_phase / 200) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) < 65);
  end

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFE;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] mode, input logic [3:0] id,
                           input logic [31:0] now, input logic [31:0] tv);
    in_ch.valid <= 1'b1;
    in_ch.data <= '{mode: mode, timer_id: id, time_now: now, time_value: tv};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  logic [31:0] clock_now;
  int burst;

  initial begin
    logic [2:0] m;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    send_item(eots_pkg::MODE_QUERY, 4'd0, 32'd0, 32'd0);
    send_item(eots_pkg::MODE_SET_DUR, 4'd1, 32'd0, 32'hFFFF_FFFE);
    send_item(eots_pkg::MODE_START_AFTER, 4'd1, 32'd5, 32'd0);
    send_item(eots_pkg::MODE_SET_DUR, 4'd2, 32'd0, 32'd10);
    send_item(eots_pkg::MODE_START_AFTER, 4'd2, 32'hFFFF_FFF8, 32'd0);
    send_item(eots_pkg::MODE_START_AT, 4'd3, 32'd0, 32'hFFFF_FFFF);
    send_item(eots_pkg::MODE_START_AT, 4'd4, 32'd0, 32'd100);
    send_item(eots_pkg::MODE_START_AT, 4'd5, 32'd0, 32'd100);
    send_item(eots_pkg::MODE_START_AT, 4'd4, 32'd0, 32'd50);
    send_item(eots_pkg::MODE_STOP, 4'd6, 32'd0, 32'd0);
    send_item(eots_pkg::MODE_TRIGGER, 4'd15, 32'd10, 32'd0);
    send_item(eots_pkg::MODE_TRIGGER, 4'd0, 32'd100, 32'd0);
    send_item(eots_pkg::MODE_STOP, 4'd1, 32'd0, 32'd0);
    send_item(3'd6, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 4'd15, 32'd0, 32'd0);
    send_item(eots_pkg::MODE_TRIGGER, 4'd0, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < 16; i++)
      send_item(eots_pkg::MODE_START_AT, i[3:0], 32'd0, 32'd7 - 32'(i % 3));
    send_item(eots_pkg::MODE_TRIGGER, 4'd0, 32'd7, 32'd0);
    idle_gap(1);
    // long receiver hold-off while offering items
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_item(eots_pkg::MODE_QUERY, i[3:0], 32'd0, 32'd0);
    join
    // random: mostly well-formed timer traffic around an advancing clock
    clock_now = 32'd0;
    for (int n = 0; n < 360; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        if ($urandom_range(0, 29) == 0) clock_now = pick_time();
        else clock_now = clock_now + $urandom_range(0, 20);
        case ($urandom_range(0, 9))
          0, 1: send_item(eots_pkg::MODE_START_AFTER, 4'($urandom), clock_now, $urandom);
          2: send_item(eots_pkg::MODE_START_AT, 4'($urandom), clock_now,
                       ($urandom_range(0, 3) == 0) ? pick_time()
                                                   : clock_now + $urandom_range(0, 40));
          3: send_item(eots_pkg::MODE_STOP, 4'($urandom), clock_now, $urandom);
          4: send_item(eots_pkg::MODE_SET_DUR, 4'($urandom), clock_now,
                       ($urandom_range(0, 3) == 0) ? pick_time() : $urandom_range(0, 50));
          5, 6, 7: send_item(eots_pkg::MODE_TRIGGER, 4'($urandom), clock_now, $urandom);
          default: begin
            m = 3'($urandom_range(0, 7));
            send_item(m, 4'($urandom), pick_time(), pick_time());
          end
        endcase
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
    end
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20 * 17) @(posedge clk);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/eots_pkg.sv
rtl/eots_if.sv
rtl/eots_cell.sv
rtl/expiry_ordered_timer_set_core.sv
rtl/eots_checker.sv
test/eots_checker.sv
test/tb_top.sv
